[rtl/core/blb_pkg.sv]
`default_nettype none

package blb_pkg;

    localparam int BAR_W   = 6;
    localparam int LVL_W   = 16;
    localparam int COEF_W  = 16;
    localparam int FALL_W  = 10;
    localparam int HOLD_W  = 8;
    localparam int VEL_W   = 18;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [LVL_W:0]    KICK_THRESH = 17'd1311;
    localparam logic [COEF_W-1:0] KICK_GAIN   = 16'd11796;

    localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd32768;
    localparam logic [COEF_W-1:0] DECAY_RST   = 16'd51118;
    localparam logic [COEF_W-1:0] GLOW_RST    = 16'd60293;
    localparam logic [FALL_W-1:0] FALL_RST    = 10'd197;
    localparam logic [HOLD_W-1:0] HOLD_RST    = 8'd22;
    localparam logic [COEF_W-1:0] GRAVITY_RST = 16'd2294;

    typedef enum logic [2:0] {
        REG_ATTACK  = 3'd0,
        REG_DECAY   = 3'd1,
        REG_GLOW    = 3'd2,
        REG_FALL    = 3'd3,
        REG_HOLD    = 3'd4,
        REG_GRAVITY = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SMUL,
        ST_SFIN,
        ST_GMUL,
        ST_KMUL,
        ST_BALL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [LVL_W-1:0]        smooth;
        logic [LVL_W-1:0]        glow;
        logic [LVL_W-1:0]        peak;
        logic [HOLD_W-1:0]       hold;
        logic [LVL_W-1:0]        pos;
        logic signed [VEL_W-1:0] vel;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[rtl/core/blb_ifs.sv]
`default_nettype none

interface blb_in_if;
    logic                       valid;
    logic                       ready;
    logic [blb_pkg::BAR_W-1:0]  bar_index;
    logic [blb_pkg::LVL_W-1:0]  level;

    modport source (output valid, output bar_index, output level, input ready);
    modport sink   (input valid, input bar_index, input level, output ready);
endinterface

interface blb_out_if;
    logic                       valid;
    logic                       ready;
    logic [blb_pkg::BAR_W-1:0]  out_bar;
    logic [blb_pkg::LVL_W-1:0]  smoothed;
    logic [blb_pkg::LVL_W-1:0]  glow;
    logic [blb_pkg::LVL_W-1:0]  peak;
    logic [blb_pkg::LVL_W-1:0]  ball_pos;

    modport source (output valid, output out_bar, output smoothed, output glow,
                    output peak, output ball_pos, input ready);
    modport sink   (input valid, input out_bar, input smoothed, input glow,
                    input peak, input ball_pos, output ready);
endinterface

`default_nettype wire

[rtl/core/blb_ram.sv]
`default_nettype none

module blb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/bar_level_ballistics_core.sv]
`default_nettype none

// Per-bar meter ballistics: smoothed level, afterglow, held/falling peak and a
// bouncing marker, with all per-bar state in one RAM word. A transaction steps
// through a read, three passes through one shared 18x18 multiplier, an update and
// write-back; a bar index at or above NUM_BARS skips these and yields zeros. Any
// result may wait on out_ch.ready. in_ch.ready is high only while the sequencer is
// idle; a finished result sits in the output register so the next transaction
// can be taken meanwhile. Per-entry valid flops make reset clear the state at once.
module bar_level_ballistics_core #(
    parameter int NUM_BARS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    blb_in_if.sink                             in_ch,
    blb_out_if.source                          out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [blb_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [blb_pkg::PDATA_W-1:0]   pwdata,
    output logic      [blb_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int MAX_BARS = 2 ** blb_pkg::BAR_W;
    localparam int DEPTH    = (NUM_BARS < MAX_BARS) ? NUM_BARS : MAX_BARS;
    localparam int AW       = $clog2(DEPTH);

    localparam int LW = blb_pkg::LVL_W;
    localparam int VW = blb_pkg::VEL_W;
    localparam int PW = blb_pkg::PROD_W;

    // config registers
    logic [blb_pkg::COEF_W-1:0] attack_reg;
    logic [blb_pkg::COEF_W-1:0] decay_reg;
    logic [blb_pkg::COEF_W-1:0] glow_decay_reg;
    logic [blb_pkg::FALL_W-1:0] peak_fall_reg;
    logic [blb_pkg::HOLD_W-1:0] peak_hold_reg;
    logic [blb_pkg::COEF_W-1:0] gravity_reg;

    logic cfg_wr;
    blb_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = blb_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg     <= blb_pkg::ATTACK_RST;
            decay_reg      <= blb_pkg::DECAY_RST;
            glow_decay_reg <= blb_pkg::GLOW_RST;
            peak_fall_reg  <= blb_pkg::FALL_RST;
            peak_hold_reg  <= blb_pkg::HOLD_RST;
            gravity_reg    <= blb_pkg::GRAVITY_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                blb_pkg::REG_ATTACK:  attack_reg     <= pwdata[blb_pkg::COEF_W-1:0];
                blb_pkg::REG_DECAY:   decay_reg      <= pwdata[blb_pkg::COEF_W-1:0];
                blb_pkg::REG_GLOW:    glow_decay_reg <= pwdata[blb_pkg::COEF_W-1:0];
                blb_pkg::REG_FALL:    peak_fall_reg  <= pwdata[blb_pkg::FALL_W-1:0];
                blb_pkg::REG_HOLD:    peak_hold_reg  <= pwdata[blb_pkg::HOLD_W-1:0];
                blb_pkg::REG_GRAVITY: gravity_reg    <= pwdata[blb_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            blb_pkg::REG_ATTACK:  prdata = {16'd0, attack_reg};
            blb_pkg::REG_DECAY:   prdata = {16'd0, decay_reg};
            blb_pkg::REG_GLOW:    prdata = {16'd0, glow_decay_reg};
            blb_pkg::REG_FALL:    prdata = {22'd0, peak_fall_reg};
            blb_pkg::REG_HOLD:    prdata = {24'd0, peak_hold_reg};
            blb_pkg::REG_GRAVITY: prdata = {16'd0, gravity_reg};
            default:              prdata = '0;
        endcase
    end

    // sequencer
    blb_pkg::state_t state_reg;
    blb_pkg::state_t state_next;

    logic in_ready;
    logic in_fire;
    logic in_range;
    logic out_free;
    logic do_out;

    logic [blb_pkg::BAR_W-1:0] bar_reg;
    logic [LW-1:0]             lvl_reg;
    logic                      oor_reg;
    blb_pkg::entry_t           cur_reg;
    logic signed [PW-1:0]      prod_reg;
    logic [DEPTH-1:0]          valid_reg;

    logic [AW-1:0]             waddr;
    blb_pkg::entry_t           ram_rdata;

    assign in_fire  = in_ch.valid && in_ready;
    assign in_range = (32'(in_ch.bar_index) < NUM_BARS);
    assign out_free = !out_ch.valid || out_ch.ready;
    assign waddr    = bar_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            blb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = in_range ? blb_pkg::ST_READ : blb_pkg::ST_DONE;
                end
            end
            blb_pkg::ST_READ: state_next = blb_pkg::ST_SMUL;
            blb_pkg::ST_SMUL: state_next = blb_pkg::ST_SFIN;
            blb_pkg::ST_SFIN: state_next = blb_pkg::ST_GMUL;
            blb_pkg::ST_GMUL: state_next = blb_pkg::ST_KMUL;
            blb_pkg::ST_KMUL: state_next = blb_pkg::ST_BALL;
            blb_pkg::ST_BALL: state_next = blb_pkg::ST_DONE;
            blb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = blb_pkg::ST_IDLE;
                end
            end
            default: state_next = blb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        do_out   = 1'b0;
        unique case (state_reg)
            blb_pkg::ST_IDLE: in_ready = 1'b1;
            blb_pkg::ST_DONE: do_out   = out_free;
            default: ;
        endcase
    end

    assign in_ch.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // shared multiplier
    logic [LW-1:0]             coef_sel;
    logic signed [VW-1:0]      mul_a;
    logic signed [VW-1:0]      mul_b;

    assign coef_sel = (lvl_reg > cur_reg.smooth) ? attack_reg : decay_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            blb_pkg::ST_SMUL:
            begin
                // old*a + lvl*(1-a) == lvl + (old-lvl)*a
                mul_a = $signed({2'b00, cur_reg.smooth}) - $signed({2'b00, lvl_reg});
                mul_b = $signed({2'b00, coef_sel});
            end
            blb_pkg::ST_GMUL:
            begin
                mul_a = $signed({2'b00, cur_reg.glow});
                mul_b = $signed({2'b00, glow_decay_reg});
            end
            blb_pkg::ST_KMUL:
            begin
                mul_a = $signed({2'b00, cur_reg.smooth});
                mul_b = $signed({2'b00, blb_pkg::KICK_GAIN});
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // smoothing
    logic signed [PW-1:0] smooth_sum;
    logic [LW-1:0]        s_new;

    assign smooth_sum = $signed({4'd0, lvl_reg, 16'd0}) + prod_reg + PW'(32768);
    assign s_new      = smooth_sum[31:16];

    // marker
    logic                 kick;
    logic [PW-1:0]        kick_sum;
    logic signed [VW-1:0] vel_a;
    logic [LW-1:0]        pos_a;
    logic signed [VW:0]   pos_sum;
    logic signed [VW:0]   vel_sum;
    logic signed [VW-1:0] vel_c;

    assign kick     = {1'b0, cur_reg.smooth} > ({1'b0, cur_reg.pos} + blb_pkg::KICK_THRESH);
    assign kick_sum = prod_reg + PW'(32768);
    assign vel_a    = kick ? $signed(kick_sum[33:16]) : cur_reg.vel;
    assign pos_a    = kick ? cur_reg.smooth : cur_reg.pos;
    assign pos_sum  = $signed({3'b000, pos_a}) + $signed({vel_a[VW-1], vel_a});
    assign vel_sum  = $signed({vel_a[VW-1], vel_a}) - $signed({3'b000, gravity_reg});
    assign vel_c    = (vel_sum[VW] && !vel_sum[VW-1]) ? {1'b1, {(VW-1){1'b0}}}
                                                      : vel_sum[VW-1:0];

    always_ff @(posedge clk)
    begin
        case (state_reg)
            blb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    bar_reg <= in_ch.bar_index;
                    lvl_reg <= in_ch.level;
                    oor_reg <= !in_range;
                end
            end
            blb_pkg::ST_READ:
            begin
                cur_reg <= valid_reg[waddr] ? ram_rdata : '0;
            end
            blb_pkg::ST_SFIN:
            begin
                cur_reg.smooth <= s_new;
            end
            blb_pkg::ST_GMUL:
            begin
                if (cur_reg.smooth > cur_reg.peak)
                begin
                    cur_reg.peak <= cur_reg.smooth;
                    cur_reg.hold <= peak_hold_reg;
                end
                else if (cur_reg.hold != '0)
                begin
                    cur_reg.hold <= cur_reg.hold - 1'b1;
                end
                else
                begin
                    cur_reg.peak <= (cur_reg.peak > LW'(peak_fall_reg))
                                    ? cur_reg.peak - LW'(peak_fall_reg) : '0;
                end
            end
            blb_pkg::ST_KMUL:
            begin
                cur_reg.glow <= (cur_reg.smooth > cur_reg.glow) ? cur_reg.smooth
                                                                : prod_reg[31:16];
            end
            blb_pkg::ST_BALL:
            begin
                if (pos_sum[VW])
                begin
                    cur_reg.pos <= '0;
                    cur_reg.vel <= '0;
                end
                else
                begin
                    cur_reg.pos <= (pos_sum[VW-1:LW] != '0) ? {LW{1'b1}} : pos_sum[LW-1:0];
                    cur_reg.vel <= vel_c;
                end
            end
            default: ;
        endcase
    end

    // state RAM and reset tracking
    blb_ram #(
        .WIDTH (blb_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (do_out && !oor_reg),
        .waddr (waddr),
        .wdata (cur_reg),
        .raddr (in_ch.bar_index[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (do_out && !oor_reg)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // output register
    logic          out_valid_reg;
    logic [blb_pkg::BAR_W-1:0] out_bar_reg;
    logic [LW-1:0] out_smooth_reg;
    logic [LW-1:0] out_glow_reg;
    logic [LW-1:0] out_peak_reg;
    logic [LW-1:0] out_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_out)
        begin
            out_bar_reg    <= bar_reg;
            out_smooth_reg <= oor_reg ? '0 : cur_reg.smooth;
            out_glow_reg   <= oor_reg ? '0 : cur_reg.glow;
            out_peak_reg   <= oor_reg ? '0 : cur_reg.peak;
            out_pos_reg    <= oor_reg ? '0 : cur_reg.pos;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_bar  = out_bar_reg;
    assign out_ch.smoothed = out_smooth_reg;
    assign out_ch.glow     = out_glow_reg;
    assign out_ch.peak     = out_peak_reg;
    assign out_ch.ball_pos = out_pos_reg;

endmodule

`default_nettype wire

[sim/bar_level_ballistics_core_tb.sv]
`timescale 1ns / 100ps

module bar_level_ballistics_core_tb;

    localparam int BAR_W   = blb_pkg::BAR_W;
    localparam int LVL_W   = blb_pkg::LVL_W;
    localparam int COEF_W  = blb_pkg::COEF_W;
    localparam int FALL_W  = blb_pkg::FALL_W;
    localparam int HOLD_W  = blb_pkg::HOLD_W;
    localparam int VEL_W   = blb_pkg::VEL_W;
    localparam int PADDR_W = blb_pkg::PADDR_W;
    localparam int PDATA_W = blb_pkg::PDATA_W;

    localparam int NUM_BARS         = 64;
    localparam int NUM_REGS         = 6;
    localparam int RAND_PHASES      = 8;
    localparam int ITEMS_PER_PHASE  = 152;
    localparam int HOLDOFF_CYCLES   = 300;
    localparam int SETTLE_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MARKER_KICK_MIN  = 1311;
    localparam int MARKER_KICK_GAIN = 11796;
    localparam int MARKER_VEL_HI    = 131071;
    localparam int MARKER_VEL_LO    = -131072;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [BAR_W-1:0] bar;
        logic [LVL_W-1:0] level;
    } level_item_t;

    typedef struct packed {
        logic [BAR_W-1:0] bar;
        logic [LVL_W-1:0] smoothed;
        logic [LVL_W-1:0] glow;
        logic [LVL_W-1:0] peak;
        logic [LVL_W-1:0] ball_pos;
    } bar_reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    blb_in_if  level_ch ();
    blb_out_if reading_ch ();

    bar_level_ballistics_core #(
        .NUM_BARS(NUM_BARS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (level_ch),
        .out_ch  (reading_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // register shadow
    logic [COEF_W-1:0] cfg_attack  = blb_pkg::ATTACK_RST;
    logic [COEF_W-1:0] cfg_decay   = blb_pkg::DECAY_RST;
    logic [COEF_W-1:0] cfg_glow    = blb_pkg::GLOW_RST;
    logic [FALL_W-1:0] cfg_fall    = blb_pkg::FALL_RST;
    logic [HOLD_W-1:0] cfg_hold    = blb_pkg::HOLD_RST;
    logic [COEF_W-1:0] cfg_gravity = blb_pkg::GRAVITY_RST;

    // per-bar meter state
    logic [LVL_W-1:0]        lvl_smooth     [NUM_BARS];
    logic [LVL_W-1:0]        lvl_glow       [NUM_BARS];
    logic [LVL_W-1:0]        lvl_peak       [NUM_BARS];
    logic [HOLD_W-1:0]       peak_hold_left [NUM_BARS];
    logic [LVL_W-1:0]        marker_pos     [NUM_BARS];
    logic signed [VEL_W-1:0] marker_vel     [NUM_BARS];

    level_item_t  levels_to_send [$];
    bar_reading_t readings_due   [$];

    logic idle_on = 1'b1;
    logic in_took;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   holdoff_req = 0;
    int   holdoff_seen = 0;
    int   holdoff_left = 0;
    int   quiet_cycles;
    int   levels_taken;
    int   readings_seen;
    int   mismatches;
    int   tb_errors = 0;
    int   settings_used = 0;
    int   cfg_writes = 0;

    function automatic bar_reading_t step_bar(input logic [BAR_W-1:0] bar,
                                              input logic [LVL_W-1:0] lvl);
        bar_reading_t     r;
        logic [63:0]      w;
        logic [63:0]      acc;
        logic [LVL_W-1:0] s;
        logic [LVL_W-1:0] p;
        int               pos;
        int               vel;
        r = '0;
        r.bar = bar;
        if (int'(bar) >= NUM_BARS)
            return r;

        w = (lvl > lvl_smooth[bar]) ? 64'(cfg_attack) : 64'(cfg_decay);
        acc = (64'(lvl_smooth[bar]) * w + 64'(lvl) * (64'd65536 - w) + 64'd32768) >> 16;
        s = (acc > 64'd65535) ? 16'hFFFF : acc[LVL_W-1:0];
        lvl_smooth[bar] = s;

        if (s > lvl_glow[bar])
            lvl_glow[bar] = s;
        else
            lvl_glow[bar] = LVL_W'((64'(lvl_glow[bar]) * 64'(cfg_glow)) >> 16);

        p = lvl_peak[bar];
        if (s > p)
        begin
            p = s;
            peak_hold_left[bar] = cfg_hold;
        end
        else if (peak_hold_left[bar] != '0)
            peak_hold_left[bar] = peak_hold_left[bar] - 1'b1;
        else
            p = (p > LVL_W'(cfg_fall)) ? p - LVL_W'(cfg_fall) : '0;
        lvl_peak[bar] = p;

        pos = int'(marker_pos[bar]);
        vel = int'(marker_vel[bar]);
        if (int'(s) > pos + MARKER_KICK_MIN)
        begin
            vel = int'((64'(s) * 64'(MARKER_KICK_GAIN) + 64'd32768) >> 16);
            pos = int'(s);
        end
        pos = pos + vel;
        vel = vel - int'(cfg_gravity);
        if (vel > MARKER_VEL_HI)
            vel = MARKER_VEL_HI;
        if (vel < MARKER_VEL_LO)
            vel = MARKER_VEL_LO;
        if (pos < 0)
        begin
            pos = 0;
            vel = 0;
        end
        if (pos > 65535)
            pos = 65535;
        marker_pos[bar] = pos[LVL_W-1:0];
        marker_vel[bar] = vel[VEL_W-1:0];

        r.smoothed = s;
        r.glow     = lvl_glow[bar];
        r.peak     = p;
        r.ball_pos = pos[LVL_W-1:0];
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [LVL_W-1:0] exp_v,
                                         input logic [LVL_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    // driver: level transactions
    always @(negedge clk)
    begin
        level_item_t nxt;
        if (!rst_n)
            level_ch.valid <= 1'b0;
        else if (level_ch.valid && !in_took)
            ;
        else if (src_gap > 0)
        begin
            level_ch.valid <= 1'b0;
            src_gap = src_gap - 1;
        end
        else if (levels_to_send.size() != 0)
        begin
            nxt = levels_to_send.pop_front();
            level_ch.valid     <= 1'b1;
            level_ch.bar_index <= nxt.bar;
            level_ch.level     <= nxt.level;
            if (idle_on && $urandom_range(0, 5) == 0)
                src_gap = $urandom_range(1, 14);
        end
        else
            level_ch.valid <= 1'b0;
    end

    // receiver: ready with random stalls and a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            reading_ch.ready <= 1'b0;
        else if (holdoff_seen != holdoff_req)
        begin
            holdoff_seen = holdoff_req;
            holdoff_left = HOLDOFF_CYCLES - 1;
            reading_ch.ready <= 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left = holdoff_left - 1;
            reading_ch.ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap = sink_gap - 1;
            reading_ch.ready <= 1'b0;
        end
        else
        begin
            reading_ch.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 6) == 0)
                sink_gap = $urandom_range(1, 14);
        end
    end

    // monitor: prediction on accepted levels, check on accepted readings, watchdog
    always @(posedge clk or negedge rst_n)
    begin
        bar_reading_t due;
        int           bad;
        if (!rst_n)
        begin
            in_took       <= 1'b0;
            quiet_cycles  = 0;
            levels_taken  = 0;
            readings_seen = 0;
            mismatches    = 0;
            for (int i = 0; i < NUM_BARS; i++)
            begin
                lvl_smooth[i]     = '0;
                lvl_glow[i]       = '0;
                lvl_peak[i]       = '0;
                peak_hold_left[i] = '0;
                marker_pos[i]     = '0;
                marker_vel[i]     = '0;
            end
        end
        else
        begin
            in_took <= level_ch.valid && level_ch.ready;
            if (level_ch.valid && level_ch.ready)
            begin
                readings_due.push_back(step_bar(level_ch.bar_index, level_ch.level));
                levels_taken = levels_taken + 1;
            end
            if (reading_ch.valid && reading_ch.ready)
            begin
                readings_seen = readings_seen + 1;
                if (readings_due.size() == 0)
                begin
                    $error("reading for bar %0d with none outstanding", reading_ch.out_bar);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    due = readings_due.pop_front();
                    bad = field_differs("out_bar", LVL_W'(due.bar), LVL_W'(reading_ch.out_bar));
                    bad += field_differs("smoothed", due.smoothed, reading_ch.smoothed);
                    bad += field_differs("glow", due.glow, reading_ch.glow);
                    bad += field_differs("peak", due.peak, reading_ch.peak);
                    bad += field_differs("ball_pos", due.ball_pos, reading_ch.ball_pos);
                    if (bad != 0)
                        mismatches = mismatches + 1;
                end
            end
            if ((level_ch.valid && level_ch.ready) || (reading_ch.valid && reading_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("bar_level_ballistics_core_tb: errors");
                $finish;
            end
        end
    end

    task automatic send(input int bar, input int lvl);
        level_item_t it;
        it.bar   = BAR_W'(bar);
        it.level = LVL_W'(lvl);
        levels_to_send.push_back(it);
    endtask

    task automatic drain();
        while (levels_to_send.size() != 0 || level_ch.valid || readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            blb_pkg::REG_ATTACK:  cfg_attack  = data[COEF_W-1:0];
            blb_pkg::REG_DECAY:   cfg_decay   = data[COEF_W-1:0];
            blb_pkg::REG_GLOW:    cfg_glow    = data[COEF_W-1:0];
            blb_pkg::REG_FALL:    cfg_fall    = data[FALL_W-1:0];
            blb_pkg::REG_HOLD:    cfg_hold    = data[HOLD_W-1:0];
            blb_pkg::REG_GRAVITY: cfg_gravity = data[COEF_W-1:0];
            default: ;
        endcase
        cfg_writes = cfg_writes + 1;
    endtask

    task automatic cfg_check(input blb_pkg::reg_idx_t r);
        logic [PDATA_W-1:0] got;
        logic [PDATA_W-1:0] want;
        case (r)
            blb_pkg::REG_ATTACK:  want = PDATA_W'(cfg_attack);
            blb_pkg::REG_DECAY:   want = PDATA_W'(cfg_decay);
            blb_pkg::REG_GLOW:    want = PDATA_W'(cfg_glow);
            blb_pkg::REG_FALL:    want = PDATA_W'(cfg_fall);
            blb_pkg::REG_HOLD:    want = PDATA_W'(cfg_hold);
            default:              want = PDATA_W'(cfg_gravity);
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", r.name(), want, got);
            tb_errors = tb_errors + 1;
        end
    endtask

    function automatic logic [PDATA_W-1:0] pick_setting(input blb_pkg::reg_idx_t r);
        int lo;
        int hi;
        logic [PDATA_W-1:0] v;
        lo = 0;
        hi = 65535;
        if (r == blb_pkg::REG_FALL)
        begin
            lo = 39;
            hi = 917;
        end
        if (r == blb_pkg::REG_HOLD)
            hi = 255;
        case ($urandom_range(0, 5))
            0: v = PDATA_W'(lo);
            1: v = PDATA_W'(hi);
            2: v = $urandom;
            default:
                v = (r == blb_pkg::REG_HOLD) ? PDATA_W'($urandom_range(0, 12))
                                             : PDATA_W'($urandom_range(hi, lo));
        endcase
        return v;
    endfunction

    // bursts of levels per bar: strikes, ramps, steady levels, alternation, noise
    task automatic queue_burst(inout int n);
        int bar;
        int bar2;
        int len;
        int lvl;
        int step;
        bar  = $urandom_range(0, NUM_BARS - 1);
        bar2 = $urandom_range(0, NUM_BARS - 1);
        len  = $urandom_range(3, 24);
        lvl  = $urandom_range(0, 65535);
        step = $urandom_range(1, 8000);
        for (int k = 0; k < len; k++)
        begin
            case (n % 7 == 0 ? 0 : (bar % 6))
                0: send($urandom_range(0, NUM_BARS - 1), $urandom_range(0, 65535));
                1:
                begin
                    if (k == 0)
                        send(bar, $urandom_range(32768, 65535));
                    else
                        send(bar, $urandom_range(0, 2000));
                end
                2:
                begin
                    send(bar, lvl);
                    lvl = (lvl + step > 65535) ? 65535 : lvl + step;
                end
                3: send(bar, lvl);
                4: send((k % 2 == 0) ? bar : bar2, $urandom_range(0, 65535));
                default: send(bar, (k % 2 == 0) ? 65535 : 0);
            endcase
            n = n + 1;
        end
    endtask

    initial
    begin
        int n;
        level_ch.valid     = 1'b0;
        level_ch.bar_index = '0;
        level_ch.level     = '0;
        reading_ch.ready   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: full-scale rise, fall to silence, kick threshold edges
        settings_used = 1;
        send(0, 65535);
        send(0, 65535);
        send(0, 65535);
        repeat (4) send(0, 0);
        send(63, 65535);
        send(63, 1);
        send(1, 2621);
        send(2, 2623);
        repeat (3) send(5, 32768);
        send(42, 21845);
        send(21, 43690);
        drain();

        // extreme settings, wide write data, writes to unmapped registers
        cfg_write(blb_pkg::REG_ATTACK, 32'h0000_0000);
        cfg_write(blb_pkg::REG_DECAY, 32'hFFFF_FFFF);
        cfg_write(blb_pkg::REG_GLOW, 32'hFFFF_0000);
        cfg_write(blb_pkg::REG_FALL, 32'hFFFF_FFFF);
        cfg_write(blb_pkg::REG_HOLD, 32'hFFFF_FF00);
        cfg_write(blb_pkg::REG_GRAVITY, 32'hFFFF_FFFF);
        cfg_write(REG_SPARE_A, $urandom);
        cfg_write(REG_SPARE_B, $urandom);
        for (int i = 0; i < NUM_REGS; i++)
            cfg_check(blb_pkg::reg_idx_t'(i));
        settings_used = settings_used + 1;
        send(7, 65535);
        repeat (4) send(7, 0);
        send(7, 40000);
        repeat (2) send(7, 0);
        send(9, 1);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_on = (ph != 3) && (ph != RAND_PHASES - 1);
            if (ph == 0)
            begin
                cfg_write(blb_pkg::REG_ATTACK, PDATA_W'(blb_pkg::ATTACK_RST));
                cfg_write(blb_pkg::REG_DECAY, PDATA_W'(blb_pkg::DECAY_RST));
                cfg_write(blb_pkg::REG_GLOW, PDATA_W'(blb_pkg::GLOW_RST));
                cfg_write(blb_pkg::REG_FALL, PDATA_W'(blb_pkg::FALL_RST));
                cfg_write(blb_pkg::REG_HOLD, PDATA_W'(blb_pkg::HOLD_RST));
                cfg_write(blb_pkg::REG_GRAVITY, PDATA_W'(blb_pkg::GRAVITY_RST));
            end
            else
            begin
                for (int i = 0; i < NUM_REGS; i++)
                    cfg_write(blb_pkg::reg_idx_t'(i), pick_setting(blb_pkg::reg_idx_t'(i)));
            end
            for (int i = 0; i < NUM_REGS; i++)
                cfg_check(blb_pkg::reg_idx_t'(i));
            settings_used = settings_used + 1;
            if (ph == 1)
                holdoff_req = holdoff_req + 1;
            n = 0;
            while (n < ITEMS_PER_PHASE)
                queue_burst(n);
            drain();
        end

        $display("summary: %0d level transactions, %0d readings checked, %0d register settings",
                 levels_taken, readings_seen, settings_used);
        $display("summary: %0d register writes, one long receiver hold-off", cfg_writes);
        if (readings_due.size() != 0)
        begin
            $error("%0d readings never arrived", readings_due.size());
            tb_errors = tb_errors + 1;
        end
        if (mismatches == 0 && tb_errors == 0)
            $display("bar_level_ballistics_core_tb: clean");
        else
            $display("bar_level_ballistics_core_tb: errors");
        $finish;
    end

endmodule
